// ----- hdl/sat_pkg.sv -----
// Shared types and constants of the software alarm table.
// Used by sat_slot_ram and software_alarm_table; depends on nothing else.
`default_nettype none

package sat_pkg;

  // Table geometry.
  localparam int NUM_SLOTS     = 8;
  localparam int DYNAMIC_START = 1;
  localparam int SLOT_W        = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int MAX_RESULTS   = 8;
  localparam int RPT_W         = $clog2(MAX_RESULTS + 1);

  // Field widths.
  localparam int FUNC_W     = 2;
  localparam int ID_W       = 4;
  localparam int EVENT_W    = 8;
  localparam int DELAY_W    = 23;
  localparam int FSLOT_W    = 3;
  localparam int ID_CMP_W   = 7;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 16;

  localparam logic [DELAY_W-1:0] ELAPSED_MAX = 23'h7FFFFF;

  // Operation codes carried in tuser.
  typedef enum logic [FUNC_W-1:0] {
    FUNC_TICK        = 2'd0,
    FUNC_CREATE_ONE  = 2'd1,
    FUNC_CREATE_PER  = 2'd2,
    FUNC_STOP        = 2'd3
  } func_e;

  // One word of the slot memory.
  typedef struct packed {
    logic [DELAY_W-1:0] delay;
    logic               periodic;
    logic [EVENT_W-1:0] event_code;
    logic [DELAY_W-1:0] elapsed;
  } slot_t;

endpackage

`default_nettype wire

// ----- hdl/software_alarm_table.sv -----
// Top level of the software alarm table: command decode, tick walker and
// result staging around the slot memory. Depends on sat_pkg and sat_slot_ram.
//
// Usage:
// Commands enter on the slave stream. tuser carries the operation (tick,
// create one-shot, create periodic, stop) and tdata the alarm id, the event
// code and the delay. Create and stop give no result.
// A tick walks the slots from 0 upward: an inactive slot is skipped, an
// active slot is read, then updated and written back. ST_FLUSH then closes
// the walk and releases the held firing.
// Each slot that fires yields one item on the master stream with its event
// code and slot index; tlast marks the last firing of the tick. A tick with
// no firing yields nothing. One firing is held back until the next is known,
// so tlast is exact; when the receiver stalls, the walk pauses on the next
// firing.
// Reset clears every active mark and all handshake state; the slot memory
// needs no clearing, since a slot is written before it becomes active.
`default_nettype none

module software_alarm_table (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  // Command items.
  input  wire                               s_axis_tvalid,
  output logic                              s_axis_tready,
  // [3:0] alarm_id, [11:4] event_code, [34:12] delay_ticks, [39:35] zero
  input  wire  [sat_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // [1:0] func
  input  wire  [sat_pkg::FUNC_W-1:0]        s_axis_tuser,
  // Result items.
  output logic                              m_axis_tvalid,
  input  wire                               m_axis_tready,
  // [7:0] fired_event, [10:8] fired_slot, [15:11] zero
  output logic [sat_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  output logic                              m_axis_tlast
);
  import sat_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_UPDATE,
    ST_FLUSH
  } state_e;

  // Command fields.
  logic [ID_W-1:0]    in_id;
  logic [EVENT_W-1:0] in_event;
  logic [DELAY_W-1:0] in_delay;
  func_e              in_func;

  assign in_id    = s_axis_tdata[ID_W-1:0];
  assign in_event = s_axis_tdata[ID_W +: EVENT_W];
  assign in_delay = s_axis_tdata[ID_W+EVENT_W +: DELAY_W];
  assign in_func  = func_e'(s_axis_tuser);

  // Control and staging registers.
  state_e              state_q, state_d;
  logic [NUM_SLOTS-1:0] active_q, active_d;
  logic [SLOT_W-1:0]   idx_q, idx_d;
  logic [RPT_W-1:0]    rpt_q, rpt_d;
  logic                pend_valid_q, pend_valid_d;
  logic [EVENT_W-1:0]  pend_event_q, pend_event_d;
  logic [FSLOT_W-1:0]  pend_slot_q, pend_slot_d;
  logic                out_valid_q, out_valid_d;
  logic [EVENT_W-1:0]  out_event_q, out_event_d;
  logic [FSLOT_W-1:0]  out_slot_q, out_slot_d;
  logic                out_last_q, out_last_d;

  // Memory ports.
  logic              mem_we, mem_re;
  logic [SLOT_W-1:0] mem_waddr;
  slot_t             mem_wdata, mem_rdata;

  sat_slot_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (idx_q),
    .rdata_o (mem_rdata)
  );

  // First inactive slot from the dynamic start upward.
  logic              dyn_found;
  logic [SLOT_W-1:0] dyn_slot;

  always_comb begin
    dyn_found = 1'b0;
    dyn_slot  = '0;
    for (int s = NUM_SLOTS - 1; s >= DYNAMIC_START; s--) begin
      if (!active_q[s]) begin
        dyn_found = 1'b1;
        dyn_slot  = SLOT_W'(s);
      end
    end
  end

  // Slot selection for create and stop.
  logic [ID_CMP_W-1:0] id_ext, id_m1;
  logic                direct_ok, stop_ok;

  assign id_ext    = ID_CMP_W'(in_id);
  assign id_m1     = id_ext - ID_CMP_W'(1);
  assign direct_ok = (in_id != '0) && (id_m1 < ID_CMP_W'(NUM_SLOTS));
  assign stop_ok   = id_ext < ID_CMP_W'(NUM_SLOTS);

  // Update of the slot under the walker.
  logic [DELAY_W-1:0] elapsed_inc;
  logic               fire, report, out_free, last_slot;

  assign elapsed_inc = (mem_rdata.elapsed < ELAPSED_MAX) ?
                       mem_rdata.elapsed + DELAY_W'(1) : mem_rdata.elapsed;
  assign fire      = elapsed_inc >= mem_rdata.delay;
  assign report    = fire && (rpt_q < RPT_W'(MAX_RESULTS));
  assign out_free  = !out_valid_q || m_axis_tready;
  assign last_slot = idx_q == SLOT_W'(NUM_SLOTS - 1);

  // Next-state logic.
  always_comb begin
    state_d      = state_q;
    active_d     = active_q;
    idx_d        = idx_q;
    rpt_d        = rpt_q;
    pend_valid_d = pend_valid_q;
    pend_event_d = pend_event_q;
    pend_slot_d  = pend_slot_q;
    out_valid_d  = out_valid_q;
    out_event_d  = out_event_q;
    out_slot_d   = out_slot_q;
    out_last_d   = out_last_q;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_waddr    = idx_q;
    mem_wdata    = mem_rdata;
    s_axis_tready = (state_q == ST_IDLE);

    // The receiver takes the output item.
    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          mem_wdata.delay      = in_delay;
          mem_wdata.periodic   = (in_func == FUNC_CREATE_PER);
          mem_wdata.event_code = in_event;
          mem_wdata.elapsed    = '0;
          unique case (in_func)
            FUNC_TICK: begin
              idx_d   = '0;
              rpt_d   = '0;
              state_d = ST_READ;
            end
            FUNC_CREATE_ONE, FUNC_CREATE_PER: begin
              if (in_id == '0) begin
                mem_waddr = dyn_slot;
                mem_we    = dyn_found;
              end else begin
                mem_waddr = SLOT_W'(id_m1);
                mem_we    = direct_ok;
              end
              if (mem_we) begin
                active_d[mem_waddr] = 1'b1;
              end
            end
            FUNC_STOP: begin
              if (stop_ok) begin
                active_d[SLOT_W'(id_ext)] = 1'b0;
              end
            end
            default: ;
          endcase
        end
      end

      // Skip an inactive slot, or read an active one.
      ST_READ: begin
        if (active_q[idx_q]) begin
          mem_re  = 1'b1;
          state_d = ST_UPDATE;
        end else if (last_slot) begin
          state_d = ST_FLUSH;
        end else begin
          idx_d = idx_q + SLOT_W'(1);
        end
      end

      // Count, fire and write back; wait if the result has nowhere to go.
      ST_UPDATE: begin
        if (!report || !pend_valid_q || out_free) begin
          mem_we = 1'b1;
          mem_wdata.elapsed = (fire && mem_rdata.periodic) ? '0 : elapsed_inc;
          if (fire && !mem_rdata.periodic) begin
            active_d[idx_q] = 1'b0;
          end
          if (report) begin
            if (pend_valid_q) begin
              out_valid_d = 1'b1;
              out_event_d = pend_event_q;
              out_slot_d  = pend_slot_q;
              out_last_d  = 1'b0;
            end
            pend_valid_d = 1'b1;
            pend_event_d = mem_rdata.event_code;
            pend_slot_d  = FSLOT_W'(idx_q);
            rpt_d        = rpt_q + RPT_W'(1);
          end
          if (last_slot) begin
            state_d = ST_FLUSH;
          end else begin
            idx_d   = idx_q + SLOT_W'(1);
            state_d = ST_READ;
          end
        end
      end

      // Release the held firing as the last one of the tick.
      ST_FLUSH: begin
        if (!pend_valid_q) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          out_valid_d  = 1'b1;
          out_event_d  = pend_event_q;
          out_slot_d   = pend_slot_q;
          out_last_d   = 1'b1;
          pend_valid_d = 1'b0;
          state_d      = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      active_q     <= '0;
      idx_q        <= '0;
      rpt_q        <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      active_q     <= active_d;
      idx_q        <= idx_d;
      rpt_q        <= rpt_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    pend_event_q <= pend_event_d;
    pend_slot_q  <= pend_slot_d;
    out_event_q  <= out_event_d;
    out_slot_q   <= out_slot_d;
    out_last_q   <= out_last_d;
  end

  // Output stream.
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_DATA_W'({out_slot_q, out_event_q});
  assign m_axis_tlast  = out_last_q;

endmodule

`default_nettype wire

// ----- hdl/sat_slot_ram.sv -----
// Slot memory of the software alarm table: one write port, one read port,
// registered read data. Depends on sat_pkg.
`default_nettype none

module sat_slot_ram (
  input  wire                      clk_i,
  input  wire                      we_i,
  input  wire  [sat_pkg::SLOT_W-1:0] waddr_i,
  input  sat_pkg::slot_t           wdata_i,
  input  wire                      re_i,
  input  wire  [sat_pkg::SLOT_W-1:0] raddr_i,
  output sat_pkg::slot_t           rdata_o
);
  import sat_pkg::*;

  slot_t mem_q [NUM_SLOTS];
  slot_t rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- tb/tb_software_alarm_table.sv -----
// Self-checking testbench for software_alarm_table: directed and random command items,
// a built-in alarm table predictor and an in-order check of every firing.
// Depends on sat_pkg and the software_alarm_table RTL only.

module tb_software_alarm_table;
  timeunit 1ns;
  timeprecision 1ps;

  import sat_pkg::*;

  localparam int DRAIN_CYCLES   = 40;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int RANDOM_ITEMS   = 125;

  // One command item as it enters the block.
  typedef struct packed {
    func_e              func;
    logic [ID_W-1:0]    alarm_id;
    logic [EVENT_W-1:0] event_code;
    logic [DELAY_W-1:0] delay_ticks;
  } command_t;

  // One firing as it leaves the block.
  typedef struct {
    logic [EVENT_W-1:0] fired_event;
    logic [FSLOT_W-1:0] fired_slot;
    logic               last;
  } firing_t;

  logic clk_i;
  logic rst_ni;

  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic [FUNC_W-1:0]     s_axis_tuser  = FUNC_TICK;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tlast;

  // Commands waiting to be sent, and firings predicted but not yet seen.
  command_t command_q[$];
  firing_t  firing_q[$];
  command_t cmd_on_bus;

  // Predicted alarm table.
  logic               tbl_active[NUM_SLOTS];
  logic [DELAY_W-1:0] tbl_elapsed[NUM_SLOTS];
  logic [EVENT_W-1:0] tbl_event[NUM_SLOTS];
  logic               tbl_periodic[NUM_SLOTS];
  logic [DELAY_W-1:0] tbl_delay[NUM_SLOTS];

  logic idle_on = 1'b1;
  int   send_gap;
  int   recv_stall;
  int   mismatches = 0;
  int   quiet_cycles;

  software_alarm_table dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  function automatic command_t make_cmd(func_e f, int id, int ev, int dly);
    command_t c;
    c.func        = f;
    c.alarm_id    = ID_W'(id);
    c.event_code  = EVENT_W'(ev);
    c.delay_ticks = DELAY_W'(dly);
    return c;
  endfunction

  // Mostly small delays so that alarms fire often; dynamic and direct ids both common.
  function automatic command_t random_command();
    command_t c;
    int       pick;
    pick = $urandom_range(0, 99);
    c.func = (pick < 45) ? FUNC_TICK :
             (pick < 65) ? FUNC_CREATE_ONE :
             (pick < 85) ? FUNC_CREATE_PER : FUNC_STOP;
    c.event_code = EVENT_W'($urandom_range(0, 255));
    pick = $urandom_range(0, 9);
    if (c.func == FUNC_STOP) begin
      c.alarm_id = ID_W'($urandom_range(0, (pick == 0) ? 15 : NUM_SLOTS - 1));
    end else begin
      c.alarm_id = (pick < 5) ? ID_W'(0) :
                   (pick < 9) ? ID_W'($urandom_range(1, NUM_SLOTS)) :
                                ID_W'($urandom_range(0, 15));
    end
    pick = $urandom_range(0, 9);
    c.delay_ticks = (pick < 7) ? DELAY_W'($urandom_range(0, 4)) :
                    (pick < 9) ? DELAY_W'($urandom_range(5, 24)) : DELAY_W'($urandom());
    return c;
  endfunction

  function automatic void arm_slot(int s, command_t c);
    tbl_event[s]    = c.event_code;
    tbl_delay[s]    = c.delay_ticks;
    tbl_periodic[s] = (c.func == FUNC_CREATE_PER);
    tbl_elapsed[s]  = '0;
    tbl_active[s]   = 1'b1;
  endfunction

  // Update the predicted table for one accepted command and queue its firings.
  function automatic void advance_alarm_table(command_t c);
    firing_t hits[MAX_RESULTS];
    int      n;
    n = 0;
    case (c.func)
      FUNC_TICK: begin
        for (int s = 0; s < NUM_SLOTS; s++) begin
          if (tbl_active[s]) begin
            if (tbl_elapsed[s] != ELAPSED_MAX) tbl_elapsed[s] = tbl_elapsed[s] + 1'b1;
            if (tbl_elapsed[s] >= tbl_delay[s]) begin
              // Only the first firings in slot order are reported.
              if (n < MAX_RESULTS) begin
                hits[n].fired_event = tbl_event[s];
                hits[n].fired_slot  = FSLOT_W'(s);
                hits[n].last        = 1'b0;
                n++;
              end
              if (tbl_periodic[s]) tbl_elapsed[s] = '0;
              else tbl_active[s] = 1'b0;
            end
          end
        end
        for (int i = 0; i < n; i++) begin
          hits[i].last = (i == n - 1);
          firing_q.push_back(hits[i]);
        end
      end
      FUNC_CREATE_ONE, FUNC_CREATE_PER: begin
        if (c.alarm_id == 0) begin
          // Dynamic allocation takes the first free slot; none free drops the create.
          for (int s = DYNAMIC_START; s < NUM_SLOTS; s++) begin
            if (!tbl_active[s]) begin
              arm_slot(s, c);
              break;
            end
          end
        end else if (int'(c.alarm_id) <= NUM_SLOTS) begin
          arm_slot(int'(c.alarm_id) - 1, c);
        end
      end
      default: begin
        if (int'(c.alarm_id) < NUM_SLOTS) tbl_active[c.alarm_id] = 1'b0;
      end
    endcase
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Command driver: holds an item until it is taken, with random gaps between items.
  always @(posedge clk_i or negedge rst_ni) begin
    logic send_now;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= FUNC_TICK;
      send_gap = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) advance_alarm_table(cmd_on_bus);
      if (!s_axis_tvalid || s_axis_tready) begin
        send_now = 1'b0;
        if (send_gap > 0) begin
          send_gap--;
        end else if (command_q.size() > 0) begin
          if (idle_on && $urandom_range(0, 5) == 0) begin
            send_gap = $urandom_range(1, 16) - 1;
          end else begin
            cmd_on_bus = command_q.pop_front();
            send_now   = 1'b1;
          end
        end
        s_axis_tvalid <= send_now;
        if (send_now) begin
          s_axis_tdata <= {5'b0, cmd_on_bus.delay_ticks, cmd_on_bus.event_code,
                           cmd_on_bus.alarm_id};
          s_axis_tuser <= cmd_on_bus.func;
        end
      end
    end
  end

  // Firing monitor: random stall bursts on tready, every accepted item checked in order.
  always @(posedge clk_i or negedge rst_ni) begin
    firing_t want;
    logic    ready_next;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      recv_stall = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (firing_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Unexpected firing: event %0d slot %0d last %0b",
                     m_axis_tdata[7:0], m_axis_tdata[10:8], m_axis_tlast);
        end else begin
          want = firing_q.pop_front();
          if (m_axis_tdata[7:0] !== want.fired_event || m_axis_tdata[10:8] !== want.fired_slot ||
              m_axis_tlast !== want.last || m_axis_tdata[15:11] !== '0) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Firing mismatch: expected event %0d slot %0d last %0b, got tdata %h last %0b",
                       want.fired_event, want.fired_slot, want.last, m_axis_tdata, m_axis_tlast);
          end
        end
      end
      ready_next = 1'b1;
      if (recv_stall > 0) begin
        recv_stall--;
        ready_next = 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        recv_stall = $urandom_range(1, 16) - 1;
        ready_next = 1'b0;
      end
      m_axis_tready <= ready_next;
    end
  end

  // Watchdog on cycles with no item accepted on either side.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    for (int s = 0; s < NUM_SLOTS; s++) begin
      tbl_active[s]   = 1'b0;
      tbl_elapsed[s]  = '0;
      tbl_event[s]    = '0;
      tbl_periodic[s] = 1'b0;
      tbl_delay[s]    = '0;
    end
    rst_ni = 1'b0;

    // Directed part: empty tick, zero and maximum delays, extreme ids and codes.
    command_q.push_back(make_cmd(FUNC_TICK, 15, 255, 23'h7FFFFF));
    command_q.push_back(make_cmd(FUNC_CREATE_ONE, 1, 8'h00, 0));
    command_q.push_back(make_cmd(FUNC_CREATE_PER, NUM_SLOTS, 8'hFF, 1));
    command_q.push_back(make_cmd(FUNC_CREATE_ONE, 0, 8'hA5, 2));
    command_q.push_back(make_cmd(FUNC_CREATE_PER, 0, 8'h5A, 0));
    // Creates with an id past the table are ignored.
    command_q.push_back(make_cmd(FUNC_CREATE_ONE, NUM_SLOTS + 1, 8'h77, 0));
    command_q.push_back(make_cmd(FUNC_CREATE_PER, 15, 8'h66, 0));
    command_q.push_back(make_cmd(FUNC_CREATE_PER, 0, 8'h3C, 23'h7FFFFF));
    command_q.push_back(make_cmd(FUNC_TICK, 0, 0, 0));
    command_q.push_back(make_cmd(FUNC_TICK, 0, 0, 0));
    command_q.push_back(make_cmd(FUNC_STOP, 2, 0, 0));
    command_q.push_back(make_cmd(FUNC_STOP, NUM_SLOTS, 0, 0));
    command_q.push_back(make_cmd(FUNC_STOP, 15, 0, 0));
    // Rearm an active slot directly, then fill the table past its last free slot.
    command_q.push_back(make_cmd(FUNC_CREATE_ONE, NUM_SLOTS, 8'h81, 3));
    command_q.push_back(make_cmd(FUNC_CREATE_PER, 4, 8'h11, 0));
    for (int i = 0; i < 6; i++)
      command_q.push_back(make_cmd((i % 2) ? FUNC_CREATE_PER : FUNC_CREATE_ONE, 0, 8'h20 + i, 0));
    command_q.push_back(make_cmd(FUNC_CREATE_PER, 1, 8'hC3, 0));
    command_q.push_back(make_cmd(FUNC_TICK, 0, 0, 0));
    command_q.push_back(make_cmd(FUNC_TICK, 0, 0, 0));
    command_q.push_back(make_cmd(FUNC_STOP, 0, 0, 0));

    for (int i = 0; i < RANDOM_ITEMS; i++) command_q.push_back(random_command());

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Alternate stretches with and without idling; the last items run without any.
    while (command_q.size() != 0 || s_axis_tvalid) begin
      @(negedge clk_i);
      idle_on = (command_q.size() > 40) && ((command_q.size() / 30) % 2 == 0);
    end
    idle_on = 1'b0;
    while (firing_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (mismatches == 0 && firing_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/sat_pkg.sv
hdl/sat_slot_ram.sv
hdl/software_alarm_table.sv
tb/tb_software_alarm_table.sv
